### sv/perc_pkg.sv
// Shared types, widths and helpers for the two-input perceptron trainer.
package perc_pkg;

  localparam int FEAT_W     = 16;
  localparam int WGT_W      = 32;
  localparam int RATE_W     = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  // Fraction bits: features FEAT_W/2, weights WGT_W/2, rate RATE_W.
  localparam int STEP_SHIFT = RATE_W + FEAT_W / 2 - WGT_W / 2;
  localparam int STEP_PROD_W = RATE_W + 1 + FEAT_W;
  localparam int DELTA_W    = STEP_PROD_W - STEP_SHIFT;
  localparam int PROD_W     = WGT_W + FEAT_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int UPD_W      = WGT_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_GAIN = 2'd0,
    REG_INIT_W1   = 2'd1,
    REG_INIT_W2   = 2'd2,
    REG_INIT_BIAS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_one;
    logic signed [FEAT_W-1:0] feature_two;
    logic                     label;
    logic                     reload;
    logic                     epoch_start;
    logic                     epoch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [WGT_W-1:0] weight_one;
    logic signed [WGT_W-1:0] weight_two;
    logic signed [WGT_W-1:0] bias_out;
    logic                    predicted;
    logic [CNT_W-1:0]        error_count;
    logic                    last_of_epoch;
  } out_item_t;

  // Captured sample plus the rounded weight steps, formed at capture time.
  typedef struct packed {
    in_item_t                  item;
    logic signed [DELTA_W-1:0] delta_one;
    logic signed [DELTA_W-1:0] delta_two;
  } stage_item_t;

  typedef struct packed {
    logic [RATE_W-1:0]       step_gain;
    logic signed [WGT_W-1:0] init_weight_one;
    logic signed [WGT_W-1:0] init_weight_two;
    logic signed [WGT_W-1:0] init_bias;
  } cfg_t;

  // Clamp a widened update result back to the signed weight range.
  function automatic logic signed [WGT_W-1:0] sat_weight(input logic signed [UPD_W-1:0] v);
    logic signed [WGT_W-1:0] res;
    if (v[UPD_W-1:WGT_W-1] == '0 || v[UPD_W-1:WGT_W-1] == '1) begin
      res = v[WGT_W-1:0];
    end else if (v[UPD_W-1]) begin
      res = {1'b1, {(WGT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WGT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### sv/perceptron_online_trainer.sv
// Top level of the online two-input perceptron trainer.
//
// Samples enter on the in_ channel (in_valid, in_stall, in_data) and one result
// item leaves on the out_ channel (out_valid, out_stall, out_data) per sample.
// An item is taken at a clock edge where valid is high and stall is low.
// A sample is held in an input register, where its two weight steps are formed
// by the learning-rate multipliers. Once the output register can take a result,
// the prediction products, the sum, the compare and the saturating update run
// in one pass into the output register and the weight registers. One sample per
// cycle is sustained while the receiver does not stall; the limit is the
// combinational loop from the weight registers through the update back.
// When the receiver stalls, the output register holds its item, the input
// register keeps the next sample, and in_stall rises only once both are full.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while no sample is in flight, and the block
// does not enforce this. Synchronous reset empties both stages, clears the
// weights, bias and error count, and restores the register defaults.
module perceptron_online_trainer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  perc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output perc_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [perc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [perc_pkg::CFG_W-1:0]    cfg_wdata
);
  import perc_pkg::*;

  localparam logic [RATE_W-1:0] STEP_GAIN_RESET = RATE_W'(6554);

  cfg_t        cfg_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_data_r;
  logic        advance;
  logic        fire;
  logic        stage_valid;
  stage_item_t stage_data;
  out_item_t   result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_gain       <= STEP_GAIN_RESET;
      cfg_r.init_weight_one <= '0;
      cfg_r.init_weight_two <= '0;
      cfg_r.init_bias       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_GAIN:  cfg_r.step_gain       <= cfg_wdata[RATE_W-1:0];
        REG_INIT_W1:    cfg_r.init_weight_one <= cfg_wdata[WGT_W-1:0];
        REG_INIT_W2:    cfg_r.init_weight_two <= cfg_wdata[WGT_W-1:0];
        REG_INIT_BIAS:  cfg_r.init_bias       <= cfg_wdata[WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The output register can take a new result when empty or being drained.
  assign advance = !out_valid_r || !out_stall;
  assign fire    = stage_valid && advance;

  perc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .step_gain   (cfg_r.step_gain),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  perc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .stage_data (stage_data),
    .cfg        (cfg_r),
    .result     (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input side only backs up when the sample stage is occupied.
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid)
    else $error("input stalled with an empty sample stage");

  // A free output side never holds back the input.
  a_free_output_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output was free");

  // A sample that moves on always shows up as a valid result.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed sample did not reach the output");

  // A correct prediction leaves the weights unchanged unless a reload applies.
  a_hit_keeps_weight: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !stage_data.item.reload && (result.predicted == stage_data.item.label)
      |=> out_data.weight_one == $past(u_core.weight_one_r))
    else $error("weight moved on a correct prediction");

endmodule

### sv/perc_front.sv
// Input register stage: captures a sample and forms its rounded weight steps.
module perc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  perc_pkg::in_item_t     in_data,
  input  logic [perc_pkg::RATE_W-1:0] step_gain,
  input  logic                   advance,
  output logic                   stage_valid,
  output perc_pkg::stage_item_t  stage_data
);
  import perc_pkg::*;

  logic                          stage_valid_r;
  logic                          stage_valid_nxt;
  stage_item_t                   stage_data_r;
  logic                          take;
  logic signed [STEP_PROD_W-1:0] prod_one;
  logic signed [STEP_PROD_W-1:0] prod_two;
  logic signed [STEP_PROD_W-1:0] rnd_one;
  logic signed [STEP_PROD_W-1:0] rnd_two;
  logic signed [STEP_PROD_W-1:0] half_lsb;

  assign in_stall = stage_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  assign half_lsb = STEP_PROD_W'(1) <<< (STEP_SHIFT - 1);
  assign prod_one = $signed({1'b0, step_gain}) * in_data.feature_one;
  assign prod_two = $signed({1'b0, step_gain}) * in_data.feature_two;
  assign rnd_one  = prod_one + half_lsb;
  assign rnd_two  = prod_two + half_lsb;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (take) begin
      stage_valid_nxt = 1'b1;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_data_r.item      <= in_data;
      stage_data_r.delta_one <= rnd_one[STEP_PROD_W-1:STEP_SHIFT];
      stage_data_r.delta_two <= rnd_two[STEP_PROD_W-1:STEP_SHIFT];
    end
  end

  assign stage_valid = stage_valid_r;
  assign stage_data  = stage_data_r;

endmodule

### sv/perc_core.sv
// Perceptron state, prediction and saturating weight update for one sample.
module perc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  perc_pkg::stage_item_t stage_data,
  input  perc_pkg::cfg_t        cfg,
  output perc_pkg::out_item_t   result
);
  import perc_pkg::*;

  logic signed [WGT_W-1:0]  weight_one_r;
  logic signed [WGT_W-1:0]  weight_two_r;
  logic signed [WGT_W-1:0]  bias_r;
  logic [CNT_W-1:0]         miss_count_r;
  logic signed [WGT_W-1:0]  weight_one_nxt;
  logic signed [WGT_W-1:0]  weight_two_nxt;
  logic signed [WGT_W-1:0]  bias_nxt;
  logic [CNT_W-1:0]         miss_count_nxt;

  logic signed [WGT_W-1:0]  w1_cur;
  logic signed [WGT_W-1:0]  w2_cur;
  logic signed [WGT_W-1:0]  b_cur;
  logic [CNT_W-1:0]         cnt_cur;
  logic signed [PROD_W-1:0] prod_one;
  logic signed [PROD_W-1:0] prod_two;
  logic signed [SUM_W-1:0]  sum;
  logic                     pred;
  logic                     miss;
  logic signed [UPD_W-1:0]  step_one;
  logic signed [UPD_W-1:0]  step_two;
  logic signed [UPD_W-1:0]  step_bias;

  // Flags act before the prediction.
  assign w1_cur  = stage_data.item.reload ? cfg.init_weight_one : weight_one_r;
  assign w2_cur  = stage_data.item.reload ? cfg.init_weight_two : weight_two_r;
  assign b_cur   = stage_data.item.reload ? cfg.init_bias : bias_r;
  assign cnt_cur = stage_data.item.epoch_start ? '0 : miss_count_r;

  assign prod_one = w1_cur * stage_data.item.feature_one;
  assign prod_two = w2_cur * stage_data.item.feature_two;
  assign sum = SUM_W'(prod_one) + SUM_W'(prod_two) + (SUM_W'(b_cur) <<< (FEAT_W / 2));
  assign pred = !sum[SUM_W-1] && (sum != '0);
  assign miss = pred != stage_data.item.label;

  // A false 1 subtracts the steps from the weights and bias, a false 0 adds them.
  always_comb begin
    step_one  = UPD_W'(stage_data.delta_one);
    step_two  = UPD_W'(stage_data.delta_two);
    step_bias = $signed({{(UPD_W-RATE_W){1'b0}}, cfg.step_gain});
    if (pred) begin
      step_one  = -step_one;
      step_two  = -step_two;
      step_bias = -step_bias;
    end
  end

  always_comb begin
    weight_one_nxt = w1_cur;
    weight_two_nxt = w2_cur;
    bias_nxt       = b_cur;
    miss_count_nxt = cnt_cur;
    if (miss) begin
      weight_one_nxt = sat_weight(UPD_W'(w1_cur) + step_one);
      weight_two_nxt = sat_weight(UPD_W'(w2_cur) + step_two);
      bias_nxt       = sat_weight(UPD_W'(b_cur) + step_bias);
      if (cnt_cur != '1) begin
        miss_count_nxt = cnt_cur + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_one_r <= '0;
      weight_two_r <= '0;
      bias_r       <= '0;
      miss_count_r <= '0;
    end else if (fire) begin
      weight_one_r <= weight_one_nxt;
      weight_two_r <= weight_two_nxt;
      bias_r       <= bias_nxt;
      miss_count_r <= miss_count_nxt;
    end
  end

  always_comb begin
    result.weight_one    = weight_one_nxt;
    result.weight_two    = weight_two_nxt;
    result.bias_out      = bias_nxt;
    result.predicted     = pred;
    result.error_count   = miss_count_nxt;
    result.last_of_epoch = stage_data.item.epoch_end;
  end

endmodule
